>>> src/swl_pkg.sv
// Shared types, constants and character decode helpers for the S-record word loader.
package swl_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [31:0] START_RESET = 32'h4000_0000;
  localparam logic [31:0] WORD_STEP   = 32'd4;
  localparam logic [3:0]  COUNT_DIGITS = 4'd2;
  localparam logic [3:0]  WORD_DIGITS  = 4'd8;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_COUNT = 3'd2,
    PH_ADDR  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5,
    PH_SKIP  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_WRITE     = 3'd0,
    KIND_START     = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_BAD_COUNT = 3'd3,
    KIND_BAD_HEX   = 3'd4
  } kind_e;

  // Pre-decoded character request
  typedef struct packed {
    logic       eoi;
    logic       space;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic [3:0] type_digit;  // 0 when not a known record type
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic [31:0] data;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "f")) ||
           ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if ((c >= "0") && (c <= "9")) v = c - 8'h30;
    else if ((c >= "a") && (c <= "f")) v = c - 8'h57;
    else if ((c >= "A") && (c <= "F")) v = c - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic [3:0] type_digit(input logic [7:0] c);
    logic [3:0] t;
    t = 4'd0;
    if ((c == "1") || (c == "2") || (c == "3") || (c == "7") || (c == "8") || (c == "9"))
      t = c[3:0];
    return t;
  endfunction

  // Address width in bytes for a record type
  function automatic logic [2:0] addr_bytes(input logic [3:0] t);
    logic [2:0] n;
    if ((t == 4'd1) || (t == 4'd9)) n = 3'd2;
    else if ((t == 4'd2) || (t == 4'd8)) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

endpackage

>>> src/swl_front.sv
// Front end: classifies incoming characters and queues them for the parser.
module swl_front
  import swl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] char_in_i,
  input  logic       end_of_input_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output cmd_t       cmd_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;
  cmd_t             cmd_in;

  always_comb begin
    cmd_in.eoi        = end_of_input_i;
    cmd_in.space      = is_space(char_in_i);
    cmd_in.hex_ok     = is_hex(char_in_i);
    cmd_in.hex_val    = hex_val(char_in_i);
    cmd_in.type_digit = type_digit(char_in_i);
  end

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(wr_en) - QCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> src/swl_back.sv
// Back end: record parser state machine, one classified character per cycle while take_i is high.
module swl_back
  import swl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic take_i,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  output res_t res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  rec_digit_q, rec_digit_d;
  logic [3:0]  dig_cnt_q, dig_cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [31:0] cur_addr_q, cur_addr_d;
  logic [31:0] start_addr_q, start_addr_d;
  logic        halted_q, halted_d;

  logic        active, hex_ph, hex_step, bad_hex, digit_ok, done;
  logic        count_done, addr_done, data_done, start_rec, malformed;
  logic [3:0]  dig_inc, need;
  logic [31:0] acc_shift;
  logic [2:0]  ab;
  logic [7:0]  bl_minus_ab, bl_minus_4;

  assign active    = take_i & ~cmd_i.eoi & ~halted_q;
  assign hex_ph    = (phase_q == PH_COUNT) || (phase_q == PH_ADDR) || (phase_q == PH_DATA);
  assign hex_step  = active & hex_ph & ~((dig_cnt_q == 4'd0) & cmd_i.space);
  assign bad_hex   = hex_step & ~cmd_i.hex_ok;
  assign digit_ok  = hex_step & cmd_i.hex_ok;
  assign dig_inc   = dig_cnt_q + 4'd1;
  assign acc_shift = {acc_q[27:0], cmd_i.hex_val};
  assign ab        = addr_bytes(rec_digit_q);

  always_comb begin
    case (phase_q)
      PH_COUNT: need = COUNT_DIGITS;
      PH_ADDR:  need = {ab, 1'b0};
      default:  need = WORD_DIGITS;
    endcase
  end

  assign done        = digit_ok & (dig_inc >= need);
  assign count_done  = done & (phase_q == PH_COUNT);
  assign addr_done   = done & (phase_q == PH_ADDR);
  assign data_done   = done & (phase_q == PH_DATA);
  assign start_rec   = (rec_digit_q >= 4'd7);
  assign bl_minus_ab = bytes_left_q - {5'd0, ab};
  assign bl_minus_4  = bytes_left_q - 8'd4;
  assign malformed   = (bytes_left_q < {5'd0, ab}) || (bl_minus_ab[1:0] != 2'b01);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (take_i && cmd_i.eoi) begin
      phase_d = PH_LEAD;
    end else if (active) begin
      case (phase_q)
        PH_LEAD:  if (!cmd_i.space) phase_d = PH_TYPE;
        PH_TYPE:  phase_d = PH_COUNT;
        PH_CHECK: if (dig_cnt_q != 4'd0) phase_d = PH_LEAD;
        PH_SKIP:  if (cmd_i.space && (dig_cnt_q != 4'd0)) phase_d = PH_LEAD;
        PH_COUNT: begin
          if (count_done) phase_d = (rec_digit_q == 4'd0) ? PH_SKIP : PH_ADDR;
        end
        PH_ADDR: begin
          if (addr_done) begin
            if (start_rec) phase_d = PH_CHECK;
            else if (malformed) phase_d = PH_LEAD;
            else phase_d = (bl_minus_ab == 8'd1) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_done) phase_d = (bl_minus_4 == 8'd1) ? PH_CHECK : PH_DATA;
        end
        default: phase_d = PH_LEAD;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    rec_digit_d  = rec_digit_q;
    dig_cnt_d    = dig_cnt_q;
    acc_d        = acc_q;
    bytes_left_d = bytes_left_q;
    cur_addr_d   = cur_addr_q;
    start_addr_d = start_addr_q;
    halted_d     = halted_q;
    res_valid_o  = 1'b0;
    res_o.kind   = KIND_DONE;
    res_o.address = '0;
    res_o.data   = '0;

    if (take_i && cmd_i.eoi) begin
      halted_d      = 1'b0;
      dig_cnt_d     = '0;
      acc_d         = '0;
      res_valid_o   = 1'b1;
      res_o.kind    = KIND_DONE;
      res_o.address = start_addr_q;
    end else if (active) begin
      case (phase_q)
        PH_TYPE: begin
          rec_digit_d = cmd_i.type_digit;
          dig_cnt_d   = '0;
          acc_d       = '0;
        end
        PH_CHECK, PH_SKIP: begin
          if (dig_cnt_q != 4'd0 && (cmd_i.space || phase_q == PH_CHECK)) begin
            dig_cnt_d = '0;
            acc_d     = '0;
          end else if (!cmd_i.space) begin
            dig_cnt_d = 4'd1;
          end
        end
        default: begin
          if (bad_hex) begin
            halted_d    = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_HEX;
          end else if (digit_ok) begin
            acc_d     = acc_shift;
            dig_cnt_d = dig_inc;
            if (done) begin
              acc_d     = '0;
              dig_cnt_d = '0;
            end
            if (count_done) begin
              bytes_left_d = acc_shift[7:0];
            end
            if (addr_done) begin
              if (start_rec) begin
                start_addr_d  = acc_shift;
                res_valid_o   = 1'b1;
                res_o.kind    = KIND_START;
                res_o.address = acc_shift;
              end else if (malformed) begin
                halted_d    = 1'b1;
                res_valid_o = 1'b1;
                res_o.kind  = KIND_BAD_COUNT;
              end else begin
                bytes_left_d = bl_minus_ab;
                cur_addr_d   = acc_shift;
              end
            end
            if (data_done) begin
              res_valid_o   = 1'b1;
              res_o.kind    = KIND_WRITE;
              res_o.address = cur_addr_q;
              res_o.data    = acc_shift;
              cur_addr_d    = cur_addr_q + WORD_STEP;
              bytes_left_d  = bl_minus_4;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEAD;
      rec_digit_q  <= '0;
      dig_cnt_q    <= '0;
      acc_q        <= '0;
      bytes_left_q <= '0;
      cur_addr_q   <= '0;
      start_addr_q <= START_RESET;
      halted_q     <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      rec_digit_q  <= rec_digit_d;
      dig_cnt_q    <= dig_cnt_d;
      acc_q        <= acc_d;
      bytes_left_q <= bytes_left_d;
      cur_addr_q   <= cur_addr_d;
      start_addr_q <= start_addr_d;
      halted_q     <= halted_d;
    end
  end

endmodule

>>> src/swl_res_fifo.sv
// Result queue between the parser and the output port.
module swl_res_fifo
  import swl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign res_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(wr_en) - QCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

>>> src/srec_word_loader.sv
// Top level of the character-serial S-record word loader.
//
// Usage:
//   Input side is a queue: drive char_in_i / end_of_input_i with push high;
//   a request is taken on a clock edge where push is high and full is low.
//   Output side is a queue: while empty is low, kind_o/address_o/data_o show
//   the oldest result; it is taken on an edge with pop high.
//   Each character gives zero or one result (word write, start address,
//   done, malformed count, bad hex digit). end_of_input_i reports the start
//   address as kind done and rearms the parser after an error.
// Throughput: one character per cycle, set by the parser step in the back
//   end; it advances whenever a classified character is queued and the
//   result queue has room.
// Path: the front queue writes a character at the edge that takes it; the
//   parser step then writes its result into the result queue, once that
//   queue has room, and the result shows on the output from there.
// Stall: when pop stays low the result queue fills, the parser stops, the
//   two-entry front queue fills and full goes high. Nothing is dropped.
// Reset: both queues empty, parser waits for a record lead, start address
//   is 0x40000000 and current address is 0.
module srec_word_loader
  import swl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_input_i,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [31:0] address_o,
  output logic [31:0] data_o
);

  cmd_t cmd;
  res_t res_in, res_out;
  logic cmd_empty, res_full, res_push, back_take;

  // Parser steps only when it has a character and room for a result
  assign back_take = ~cmd_empty & ~res_full;

  swl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .char_in_i      (char_in_i),
    .end_of_input_i (end_of_input_i),
    .full_o         (full),
    .pop_i          (back_take),
    .empty_o        (cmd_empty),
    .cmd_o          (cmd)
  );

  swl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (back_take),
    .cmd_i       (cmd),
    .res_valid_o (res_push),
    .res_o       (res_in)
  );

  swl_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out)
  );

  assign kind_o    = res_out.kind;
  assign address_o = res_out.address;
  assign data_o    = res_out.data;

  // End of input always produces a done result carrying the start address
  a_eoi_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_take && cmd.eoi) |-> (res_push && res_in.kind == KIND_DONE))
    else $error("end of input did not produce done result");

  // Results only appear when the parser consumed a character
  a_push_needs_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> back_take)
    else $error("result produced without a consumed character");

  // A result pushed into an empty queue is visible next cycle
  a_res_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && empty) |=> !empty)
    else $error("pushed result not visible");

  // Only writes carry data
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_in.kind != KIND_WRITE) |-> (res_in.data == 32'd0))
    else $error("nonzero data on non-write result");

endmodule
